// File: sv/bellman_ford_shortest_path_macros.svh
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATH_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATH_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BFSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfsp assertion failed");

// next-cycle implication, sampled on clk, quiet during reset
`define BFSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfsp assertion failed");

`endif

// File: sv/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// shared types and constants of the shortest path block
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 64;

    localparam int VTX_W   = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int WGT_W   = 16;
    localparam int DIST_W  = 32;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [VTX_W-1:0]        edge_from;
        logic [VTX_W-1:0]        edge_to;
        logic signed [WGT_W-1:0] edge_weight;
        logic [VTX_W-1:0]        start_vertex;
    } item_t;

    typedef struct packed {
        logic [VTX_W-1:0]         vertex;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic                     negative_cycle;
        logic                     last;
    } result_t;

    typedef struct packed {
        logic [VTX_W-1:0]        src;
        logic [VTX_W-1:0]        dst;
        logic signed [WGT_W-1:0] weight;
    } edge_t;

endpackage

// File: sv/bfsp_item_if.sv
// ----------------------------------------------------------------------------
// bfsp_item_if
// valid/ready channel carrying one input item per beat
// ----------------------------------------------------------------------------
interface bfsp_item_if
    import bfsp_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/bfsp_result_if.sv
// ----------------------------------------------------------------------------
// bfsp_result_if
// valid/ready channel carrying one result row per beat
// ----------------------------------------------------------------------------
interface bfsp_result_if
    import bfsp_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/bellman_ford_shortest_path.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path
// single-source shortest path over a stored list of weighted edges
// ----------------------------------------------------------------------------
// item channel: an add-edge beat appends one edge to a 64-entry edge memory
// (dropped once full) and is taken while idle. a run beat names the start
// vertex; the block then drops ready until the last result row is taken.
// result channel: one row per vertex in use, vertex 0 first, last on the
// final row. each row is held in the output register until taken, so a
// stalled receiver simply pauses the row sequencer.
// a run walks every source vertex per pass; a source with no distance is
// skipped. for each reachable source it loads the distance, then scans every
// stored edge through one shared add/saturate/compare unit: each edge is
// fetched and checked, and an edge leaving that source is relaxed in a
// further step. with n vertices a run makes n-1 passes plus the negative
// cycle check pass, then reads each row from the distance memory into the
// output register.
// cfg_wr_en/cfg_wr_data write num_vertices; 0 acts as 1, above 16 as 16.
// reset (rst_n low) empties the edge list and sets num_vertices to 16.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path
    import bfsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [VCNT_W-1:0] cfg_wr_data,
    bfsp_item_if.sink         item,
    bfsp_result_if.source     result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRC,
        S_SRCLD,
        S_EFETCH,
        S_ECHK,
        S_RELAX,
        S_ORD,
        S_OLD,
        S_OWAIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [VCNT_W-1:0]        cfg_nv_reg;
    logic [VCNT_W-1:0]        nv_reg, nv_next;
    logic [ECNT_W-1:0]        ecount_reg, ecount_next;
    logic [VCNT_W-1:0]        pass_reg, pass_next;
    logic                     check_reg, check_next;
    logic                     neg_reg, neg_next;
    logic [VCNT_W-1:0]        src_reg, src_next;
    logic [ECNT_W-1:0]        e_reg, e_next;
    logic signed [DIST_W-1:0] srcd_reg, srcd_next;
    logic signed [DIST_W-1:0] cand_reg, cand_next;
    logic [VTX_W-1:0]         to_reg, to_next;
    logic [MAX_VERTICES-1:0]  reach_reg, reach_next;
    logic [VTX_W-1:0]         row_reg, row_next;
    logic                     res_valid_reg, res_valid_next;
    result_t                  res_data_reg, res_data_next;

    // edge memory
    edge_t                    edge_mem [MAX_EDGES];
    edge_t                    edge_rd;
    logic                     edge_we;
    edge_t                    edge_wdata;

    // distance memory
    logic signed [DIST_W-1:0] dist_mem [MAX_VERTICES];
    logic signed [DIST_W-1:0] dist_rd;
    logic                     dist_we;
    logic [VTX_W-1:0]         dist_waddr;
    logic signed [DIST_W-1:0] dist_wdata;
    logic [VTX_W-1:0]         dist_raddr;

    logic [VCNT_W-1:0]        nv_eff;
    logic                     item_beat;
    logic signed [DIST_W:0]   sum_wide;
    logic signed [DIST_W-1:0] sum_sat;
    logic [VTX_W-1:0]         src_idx;

    assign item.ready   = (state_reg == S_IDLE);
    assign item_beat    = item.valid && item.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;
    assign src_idx      = src_reg[VTX_W-1:0];

    always_comb
    begin
        if (cfg_nv_reg == '0)
        begin
            nv_eff = VCNT_W'(1);
        end
        else if (cfg_nv_reg > VCNT_W'(MAX_VERTICES))
        begin
            nv_eff = VCNT_W'(MAX_VERTICES);
        end
        else
        begin
            nv_eff = cfg_nv_reg;
        end
    end

    // shared add with saturation to the signed distance range
    always_comb
    begin
        sum_wide = {srcd_reg[DIST_W-1], srcd_reg}
                 + {{(DIST_W+1-WGT_W){edge_rd.weight[WGT_W-1]}}, edge_rd.weight};
        if (sum_wide[DIST_W] != sum_wide[DIST_W-1])
        begin
            sum_sat = sum_wide[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            sum_sat = sum_wide[DIST_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        nv_next        = nv_reg;
        ecount_next    = ecount_reg;
        pass_next      = pass_reg;
        check_next     = check_reg;
        neg_next       = neg_reg;
        src_next       = src_reg;
        e_next         = e_reg;
        srcd_next      = srcd_reg;
        cand_next      = cand_reg;
        to_next        = to_reg;
        reach_next     = reach_reg;
        row_next       = row_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        edge_we        = 1'b0;
        edge_wdata     = '{src: item.data.edge_from, dst: item.data.edge_to,
                           weight: item.data.edge_weight};
        dist_we        = 1'b0;
        dist_waddr     = to_reg;
        dist_wdata     = cand_reg;
        dist_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_beat)
                begin
                    if (item.data.operation == OP_ADD_EDGE)
                    begin
                        if (ecount_reg < ECNT_W'(MAX_EDGES))
                        begin
                            edge_we     = 1'b1;
                            ecount_next = ecount_reg + ECNT_W'(1);
                        end
                    end
                    else
                    begin
                        nv_next    = nv_eff;
                        reach_next = '0;
                        if ({1'b0, item.data.start_vertex} < nv_eff)
                        begin
                            reach_next[item.data.start_vertex] = 1'b1;
                            dist_we    = 1'b1;
                            dist_waddr = item.data.start_vertex;
                            dist_wdata = '0;
                        end
                        pass_next  = VCNT_W'(1);
                        check_next = (nv_eff == VCNT_W'(1));
                        neg_next   = 1'b0;
                        src_next   = '0;
                        state_next = S_SRC;
                    end
                end
            end
            S_SRC:
            begin
                if (src_reg == nv_reg)
                begin
                    // end of a pass
                    if (check_reg)
                    begin
                        row_next   = '0;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        if (pass_reg + VCNT_W'(1) == nv_reg)
                        begin
                            check_next = 1'b1;
                        end
                        pass_next = pass_reg + VCNT_W'(1);
                        src_next  = '0;
                    end
                end
                else if (!reach_reg[src_idx])
                begin
                    src_next = src_reg + VCNT_W'(1);
                end
                else
                begin
                    dist_raddr = src_idx;
                    state_next = S_SRCLD;
                end
            end
            S_SRCLD:
            begin
                srcd_next  = dist_rd;
                e_next     = '0;
                state_next = S_EFETCH;
            end
            S_EFETCH:
            begin
                if (e_reg == ecount_reg)
                begin
                    src_next   = src_reg + VCNT_W'(1);
                    state_next = S_SRC;
                end
                else
                begin
                    state_next = S_ECHK;
                end
            end
            S_ECHK:
            begin
                if (edge_rd.src == src_idx && {1'b0, edge_rd.dst} < nv_reg)
                begin
                    cand_next  = sum_sat;
                    to_next    = edge_rd.dst;
                    dist_raddr = edge_rd.dst;
                    state_next = S_RELAX;
                end
                else
                begin
                    e_next     = e_reg + ECNT_W'(1);
                    state_next = S_EFETCH;
                end
            end
            S_RELAX:
            begin
                if (!reach_reg[to_reg] || cand_reg < dist_rd)
                begin
                    if (check_reg)
                    begin
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        dist_we            = 1'b1;
                        reach_next[to_reg] = 1'b1;
                        // self loop changes the source distance in flight
                        if (to_reg == src_idx)
                        begin
                            srcd_next = cand_reg;
                        end
                    end
                end
                e_next     = e_reg + ECNT_W'(1);
                state_next = S_EFETCH;
            end
            S_ORD:
            begin
                dist_raddr = row_reg;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                res_valid_next               = 1'b1;
                res_data_next.vertex         = row_reg;
                res_data_next.distance       = reach_reg[row_reg] ? dist_rd : DIST_MAX;
                res_data_next.reachable      = reach_reg[row_reg];
                res_data_next.negative_cycle = neg_reg;
                res_data_next.last           = ({1'b0, row_reg} + VCNT_W'(1) == nv_reg);
                state_next                   = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (result.ready)
                begin
                    res_valid_next = 1'b0;
                    if (res_data_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + VTX_W'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_nv_reg    <= VCNT_W'(MAX_VERTICES);
            nv_reg        <= VCNT_W'(MAX_VERTICES);
            ecount_reg    <= '0;
            pass_reg      <= '0;
            check_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            src_reg       <= '0;
            e_reg         <= '0;
            reach_reg     <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                cfg_nv_reg <= cfg_wr_data;
            end
            nv_reg        <= nv_next;
            ecount_reg    <= ecount_next;
            pass_reg      <= pass_next;
            check_reg     <= check_next;
            neg_reg       <= neg_next;
            src_reg       <= src_next;
            e_reg         <= e_next;
            reach_reg     <= reach_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
            res_data_reg  <= res_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srcd_reg     <= srcd_next;
        cand_reg     <= cand_next;
        to_reg       <= to_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[ecount_reg[EDGE_AW-1:0]] <= edge_wdata;
        end
        edge_rd <= edge_mem[e_reg[EDGE_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd <= dist_mem[dist_raddr];
    end

endmodule

// File: sv/bfsp_checker.sv
// ----------------------------------------------------------------------------
// bfsp_checker
// port-level checks of the shortest path block, bound to the top level
// ----------------------------------------------------------------------------
`include "bellman_ford_shortest_path_macros.svh"

module bfsp_checker
    import bfsp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item_data,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    // a pending row means a run is in progress
    `BFSP_ASSERT_NOW(a_row_blocks_items, result_valid, !item_ready)

    // a run beat closes the item channel
    `BFSP_ASSERT_NEXT(a_run_closes_items,
        item_valid && item_ready && item_data.operation == OP_RUN, !item_ready)

    // rows before the last keep the item channel closed
    `BFSP_ASSERT_NEXT(a_rows_continue,
        result_valid && result_ready && !result_data.last, !item_ready)

    // stalled row holds
    `BFSP_ASSERT_NEXT(a_row_holds, result_valid && !result_ready,
        result_valid && $stable(result_data))

endmodule

bind bellman_ford_shortest_path bfsp_checker u_bfsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_data    (item.data),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
